/* hdl/est_pkg.sv */
package est_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_THREE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_FOUR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_FIVE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE       = 3'd4;

    localparam logic [31:0] RST_STAGE_TWO   = 32'd15000;
    localparam logic [31:0] RST_STAGE_THREE = 32'd20000;
    localparam logic [31:0] RST_STAGE_FOUR  = 32'd30000;
    localparam logic [31:0] RST_STAGE_FIVE  = 32'd45000;
    localparam logic [31:0] RST_GRACE       = 32'd5000;

    localparam logic [2:0] STAGE_IDLE  = 3'd0;
    localparam logic [2:0] STAGE_ONE   = 3'd1;
    localparam logic [2:0] STAGE_TWO   = 3'd2;
    localparam logic [2:0] STAGE_THREE = 3'd3;
    localparam logic [2:0] STAGE_FOUR  = 3'd4;
    localparam logic [2:0] STAGE_FIVE  = 3'd5;

    typedef struct packed {
        logic        signal_on;
        logic [31:0] now_ms;
    } est_in_t;

    typedef struct packed {
        logic [2:0]  stage;
        logic        stage_changed;
        logic        tracking;
        logic [31:0] active_duration;
    } est_out_t;

    typedef struct packed {
        logic [31:0] stage_two_after;
        logic [31:0] stage_three_after;
        logic [31:0] stage_four_after;
        logic [31:0] stage_five_after;
        logic [31:0] grace_period;
    } est_cfg_t;

endpackage

/* hdl/est_cfg_regs.sv */
module est_cfg_regs
    import est_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output est_cfg_t              cfg
);

    est_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stage_two_after   <= RST_STAGE_TWO;
            cfg_reg.stage_three_after <= RST_STAGE_THREE;
            cfg_reg.stage_four_after  <= RST_STAGE_FOUR;
            cfg_reg.stage_five_after  <= RST_STAGE_FIVE;
            cfg_reg.grace_period      <= RST_GRACE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STAGE_TWO:   cfg_reg.stage_two_after   <= cfg_wdata;
                REG_STAGE_THREE: cfg_reg.stage_three_after <= cfg_wdata;
                REG_STAGE_FOUR:  cfg_reg.stage_four_after  <= cfg_wdata;
                REG_STAGE_FIVE:  cfg_reg.stage_five_after  <= cfg_wdata;
                REG_GRACE:       cfg_reg.grace_period      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/est_tracker.sv */
module est_tracker
    import est_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  est_cfg_t cfg,
    input  logic     step,
    input  est_in_t  sample,
    output est_out_t result
);

    logic        episode_open_reg, episode_open_next;
    logic        grace_open_reg, grace_open_next;
    logic [31:0] episode_start_reg, episode_start_next;
    logic [31:0] quiet_start_reg, quiet_start_next;
    logic [2:0]  stage_reg, stage_next;

    logic [31:0] start_eff;
    logic [31:0] elapsed;
    logic [31:0] quiet_age;
    logic [2:0]  picked;

    // episode start as it stands after this sample
    assign start_eff = episode_open_reg ? episode_start_reg : sample.now_ms;
    assign elapsed   = sample.now_ms - start_eff;
    assign quiet_age = sample.now_ms - quiet_start_reg;

    // highest stage first, so unordered thresholds resolve the same way
    always_comb begin
        if (elapsed >= cfg.stage_five_after) begin
            picked = STAGE_FIVE;
        end else if (elapsed >= cfg.stage_four_after) begin
            picked = STAGE_FOUR;
        end else if (elapsed >= cfg.stage_three_after) begin
            picked = STAGE_THREE;
        end else if (elapsed >= cfg.stage_two_after) begin
            picked = STAGE_TWO;
        end else begin
            picked = STAGE_ONE;
        end
    end

    always_comb begin
        episode_open_next  = episode_open_reg;
        grace_open_next    = grace_open_reg;
        episode_start_next = episode_start_reg;
        quiet_start_next   = quiet_start_reg;
        stage_next         = stage_reg;
        if (sample.signal_on) begin
            episode_open_next  = 1'b1;
            episode_start_next = start_eff;
            grace_open_next    = 1'b0;
            stage_next         = picked;
        end else if (episode_open_reg) begin
            if (!grace_open_reg) begin
                grace_open_next  = 1'b1;
                quiet_start_next = sample.now_ms;
            end else if (quiet_age >= cfg.grace_period) begin
                episode_open_next  = 1'b0;
                grace_open_next    = 1'b0;
                episode_start_next = '0;
                quiet_start_next   = '0;
                stage_next         = STAGE_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            episode_open_reg  <= 1'b0;
            grace_open_reg    <= 1'b0;
            episode_start_reg <= '0;
            quiet_start_reg   <= '0;
            stage_reg         <= STAGE_IDLE;
        end else if (step) begin
            episode_open_reg  <= episode_open_next;
            grace_open_reg    <= grace_open_next;
            episode_start_reg <= episode_start_next;
            quiet_start_reg   <= quiet_start_next;
            stage_reg         <= stage_next;
        end
    end

    assign result.stage           = stage_next;
    assign result.stage_changed   = (stage_next != stage_reg);
    assign result.tracking        = episode_open_next;
    assign result.active_duration = episode_open_next ? elapsed : '0;

    a_stage_matches_open: assert property (@(posedge aclk) disable iff (!aresetn)
        episode_open_reg == (stage_reg != STAGE_IDLE))
        else $error("stage and episode flag disagree");

    a_grace_inside_episode: assert property (@(posedge aclk) disable iff (!aresetn)
        grace_open_reg |-> episode_open_reg)
        else $error("grace timer running without an open episode");

    a_idle_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !sample.signal_on && !episode_open_reg)
            |=> (!episode_open_reg && stage_reg == STAGE_IDLE))
        else $error("inactive sample left idle state");

    a_on_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && sample.signal_on) |=> (episode_open_reg && !grace_open_reg))
        else $error("active sample did not leave an open episode");

endmodule

/* hdl/escalation_stage_timer.sv */
// Escalation stage timer. Each transfer on s_ carries an activity flag and a
// free-running millisecond time; each one yields exactly one transfer on m_
// with the stage (0 idle, 1 to 5), a changed flag, the tracking flag and the
// active duration. One sample per clock is sustained while m_ready is high.
// Each sample is first held in the input register; then the tracker state is
// updated and the result registered in the same cycle, which raises m_valid;
// a stalled m_ready holds the result and, once the input register is also
// full, s_ready. Thresholds and the grace period are written through
// cfg_wr_en/cfg_index/cfg_wdata and should only be changed while no samples
// are in flight; writes to unused indexes are dropped.
module escalation_stage_timer
    import est_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  est_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output est_out_t              m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    est_cfg_t cfg;
    est_out_t result;

    est_in_t  in_reg;
    logic     in_valid_reg;
    est_out_t out_reg;
    logic     out_valid_reg;
    logic     advance;

    // sample moves into the result register when that slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    est_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    est_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (advance),
        .sample  (in_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

/* tb/escalation_stage_timer_checker.sv */
module escalation_stage_timer_checker
    import est_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  est_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  est_out_t              m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned           mismatches,
    output int unsigned           reports_pending,
    output int unsigned           reports_checked,
    output int unsigned           stage_moves
);

    est_cfg_t    limits;
    logic        episode_open;
    logic        grace_open;
    logic [31:0] episode_start;
    logic [31:0] quiet_start;
    logic [2:0]  stage_now;

    est_out_t    stage_reports_due[$];

    int unsigned miss_count  = 0;
    int unsigned due_count   = 0;
    int unsigned check_count = 0;
    int unsigned move_count  = 0;

    assign mismatches      = miss_count;
    assign reports_pending = due_count;
    assign reports_checked = check_count;
    assign stage_moves     = move_count;

    // thresholds are tested from the top stage down, first hit wins
    function automatic logic [2:0] stage_for(input logic [31:0] elapsed);
        if (elapsed >= limits.stage_five_after) return STAGE_FIVE;
        if (elapsed >= limits.stage_four_after) return STAGE_FOUR;
        if (elapsed >= limits.stage_three_after) return STAGE_THREE;
        if (elapsed >= limits.stage_two_after) return STAGE_TWO;
        return STAGE_ONE;
    endfunction

    task automatic close_episode();
        episode_open  = 1'b0;
        grace_open    = 1'b0;
        episode_start = '0;
        quiet_start   = '0;
        stage_now     = STAGE_IDLE;
    endtask

    task automatic step_tracker(input est_in_t smp, output est_out_t rep);
        logic [2:0]  prior;
        logic [31:0] quiet_age;
        prior = stage_now;
        if (smp.signal_on) begin
            if (!episode_open) begin
                episode_open  = 1'b1;
                episode_start = smp.now_ms;
            end
            grace_open = 1'b0;
            stage_now  = stage_for(smp.now_ms - episode_start);
        end else if (episode_open) begin
            quiet_age = smp.now_ms - quiet_start;
            if (!grace_open) begin
                grace_open  = 1'b1;
                quiet_start = smp.now_ms;
            end else if (quiet_age >= limits.grace_period) begin
                close_episode();
            end
        end
        rep.stage           = stage_now;
        rep.stage_changed   = (stage_now != prior);
        rep.tracking        = episode_open;
        rep.active_duration = episode_open ? smp.now_ms - episode_start : '0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            miss_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        est_out_t forecast;
        est_out_t want;
        if (!aresetn) begin
            limits = {RST_STAGE_TWO, RST_STAGE_THREE, RST_STAGE_FOUR, RST_STAGE_FIVE,
                      RST_GRACE};
            close_episode();
            stage_reports_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STAGE_TWO:   limits.stage_two_after   = cfg_wdata;
                    REG_STAGE_THREE: limits.stage_three_after = cfg_wdata;
                    REG_STAGE_FOUR:  limits.stage_four_after  = cfg_wdata;
                    REG_STAGE_FIVE:  limits.stage_five_after  = cfg_wdata;
                    REG_GRACE:       limits.grace_period      = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (stage_reports_due.size() == 0) begin
                    $display({"%0t: result with nothing expected, actual stage %0d",
                              " changed %0b tracking %0b duration %0d"},
                             $time, m_data.stage, m_data.stage_changed, m_data.tracking,
                             m_data.active_duration);
                    miss_count++;
                end else begin
                    want = stage_reports_due.pop_front();
                    check_field("stage", 32'(want.stage), 32'(m_data.stage));
                    check_field("stage_changed", 32'(want.stage_changed),
                                32'(m_data.stage_changed));
                    check_field("tracking", 32'(want.tracking), 32'(m_data.tracking));
                    check_field("active_duration", want.active_duration,
                                m_data.active_duration);
                    check_count++;
                    if (want.stage_changed) move_count++;
                end
            end
            if (s_valid && s_ready) begin
                step_tracker(s_data, forecast);
                stage_reports_due.push_back(forecast);
            end
        end
        due_count <= stage_reports_due.size();
    end

endmodule

/* tb/escalation_stage_timer_tb.sv */
module escalation_stage_timer_tb;
    import est_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_GRACE + 1'b1;
    localparam int unsigned          RANDOM_PHASES    = 7;
    localparam int unsigned          PHASE_SAMPLES    = 108;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    est_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    est_out_t              m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_STAGE_TWO;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned mismatches;
    int unsigned reports_pending;
    int unsigned reports_checked;
    int unsigned stage_moves;

    // stimulus-side copy of the limits, only used to aim sample times
    est_cfg_t    cur;
    int unsigned sample_count  = 0;
    int unsigned setting_count = 0;
    int unsigned burst_left    = 0;
    int unsigned ready_hold    = 0;

    always #5 aclk = ~aclk;

    escalation_stage_timer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    escalation_stage_timer_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .reports_pending (reports_pending),
        .reports_checked (reports_checked),
        .stage_moves     (stage_moves)
    );

    // result side backpressure: short random stalls, a few long ones, some free runs
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(19, 0))
                0: begin
                    m_ready    <= 1'b1;
                    ready_hold <= $urandom_range(120, 40);
                end
                1: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(50, 15);
                end
                default: begin
                    m_ready    <= ($urandom_range(2, 0) != 0);
                    ready_hold <= $urandom_range(3, 0);
                end
            endcase
        end
    end

    task automatic send_sample(input logic on, input logic [31:0] t);
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
            gap = 0;
        end else begin
            case ($urandom_range(19, 0))
                0: begin
                    burst_left = $urandom_range(100, 30);
                    gap        = 0;
                end
                1: gap = $urandom_range(50, 15);
                default: gap = ($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0;
            endcase
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data.signal_on <= on;
        s_data.now_ms    <= t;
        do @(posedge aclk); while (!s_ready);
        sample_count++;
    endtask

    // stop feeding and let every outstanding result come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_limits(input est_cfg_t c);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_STAGE_TWO;
        cfg_wdata <= c.stage_two_after;
        @(posedge aclk);
        cfg_index <= REG_STAGE_THREE;
        cfg_wdata <= c.stage_three_after;
        @(posedge aclk);
        cfg_index <= REG_STAGE_FOUR;
        cfg_wdata <= c.stage_four_after;
        @(posedge aclk);
        cfg_index <= REG_STAGE_FIVE;
        cfg_wdata <= c.stage_five_after;
        @(posedge aclk);
        cfg_index <= REG_GRACE;
        cfg_wdata <= c.grace_period;
        @(posedge aclk);
        // unused indexes must leave everything alone
        cfg_index <= REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(2, 0));
        cfg_wdata <= $urandom();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur = c;
        setting_count++;
    endtask

    function automatic logic [31:0] pick_elapsed(input logic [31:0] last);
        logic [31:0] top_thr;
        logic [31:0] thr;
        top_thr = cur.stage_two_after;
        if (cur.stage_three_after > top_thr) top_thr = cur.stage_three_after;
        if (cur.stage_four_after > top_thr) top_thr = cur.stage_four_after;
        if (cur.stage_five_after > top_thr) top_thr = cur.stage_five_after;
        case ($urandom_range(3, 0))
            0: thr = cur.stage_two_after;
            1: thr = cur.stage_three_after;
            2: thr = cur.stage_four_after;
            default: thr = cur.stage_five_after;
        endcase
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: return thr + $urandom_range(2, 0) - 1;
            6, 7: return $urandom_range(top_thr, 0);
            8: return $urandom();
            default: return last + $urandom_range(200, 0);
        endcase
    endfunction

    function automatic logic [31:0] pick_quiet_age();
        case ($urandom_range(7, 0))
            0, 1, 2: return cur.grace_period;
            3: return cur.grace_period + 1;
            4: return cur.grace_period - 1;
            5: return $urandom_range(cur.grace_period, 0);
            6: return $urandom();
            default: return cur.grace_period - $urandom_range(3, 0);
        endcase
    endfunction

    // one activity episode: rise, climb, maybe a dip of up to the grace period, often a wind down
    task automatic run_episode();
        logic [31:0] t0;
        logic [31:0] el;
        logic [31:0] q;
        int unsigned n;
        t0 = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(60000, 0)
                                         : $urandom();
        el = '0;
        send_sample(1'b1, t0);
        n = $urandom_range(6, 1);
        repeat (n) begin
            el = pick_elapsed(el);
            send_sample(1'b1, t0 + el);
        end
        if ($urandom_range(2, 0) == 0) begin
            el = pick_elapsed(el);
            q  = t0 + el;
            send_sample(1'b0, q);
            if ($urandom_range(1, 0) != 0)
                send_sample(1'b0, q + $urandom_range(cur.grace_period, 0));
            el = pick_elapsed(el);
            send_sample(1'b1, t0 + el);
        end
        if ($urandom_range(4, 0) != 0) begin
            el = pick_elapsed(el);
            q  = t0 + el;
            send_sample(1'b0, q);
            n = $urandom_range(3, 1);
            repeat (n) send_sample(1'b0, q + pick_quiet_age());
        end
        if ($urandom_range(6, 0) == 0)
            send_sample(1'($urandom_range(1, 0)), $urandom());
    endtask

    initial begin : stimulus
        logic [31:0] base;
        est_cfg_t    c;
        cur = {RST_STAGE_TWO, RST_STAGE_THREE, RST_STAGE_FOUR, RST_STAGE_FIVE, RST_GRACE};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: idle noise, every threshold edge across the wrap, dip, close
        base = 32'hFFFF_F000;
        send_sample(1'b0, 32'd100);
        send_sample(1'b1, base);
        send_sample(1'b1, base + 32'd14999);
        send_sample(1'b1, base + 32'd15000);
        send_sample(1'b1, base + 32'd20000);
        send_sample(1'b1, base + 32'd30000);
        send_sample(1'b1, base + 32'd45000);
        send_sample(1'b0, base + 32'd46000);
        send_sample(1'b1, base + 32'd47000);
        send_sample(1'b0, base + 32'd50000);
        send_sample(1'b0, base + 32'd54999);
        send_sample(1'b0, base + 32'd55000);
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'hFFFF_FFFF);

        // zero limits: zero grace closes on the second quiet sample, rise jumps to the top
        load_limits('0);
        send_sample(1'b0, 32'd500);
        send_sample(1'b0, 32'd500);
        send_sample(1'b1, 32'd777);

        // all-ones limits: only the largest age reaches anything
        load_limits('1);
        send_sample(1'b1, 32'd778);
        send_sample(1'b1, 32'd776);
        send_sample(1'b0, 32'd1000);
        send_sample(1'b0, 32'd1000 + 32'hFFFF_FFFE);
        send_sample(1'b0, 32'd999);

        // out-of-order thresholds: the highest stage is tested first
        c.stage_two_after   = 32'd100;
        c.stage_three_after = 32'd50;
        c.stage_four_after  = 32'd10;
        c.stage_five_after  = 32'd1000;
        c.grace_period      = 32'd20;
        load_limits(c);
        send_sample(1'b1, 32'd5000);
        send_sample(1'b1, 32'd5060);
        send_sample(1'b1, 32'd5005);
        send_sample(1'b1, 32'd6000);

        for (int unsigned k = 0; k < RANDOM_PHASES; k++) begin
            case (k)
                0: c = {RST_STAGE_TWO, RST_STAGE_THREE, RST_STAGE_FOUR, RST_STAGE_FIVE,
                        RST_GRACE};
                1: begin
                    base                = $urandom_range(200, 1);
                    c.stage_two_after   = base;
                    c.stage_three_after = base * 2;
                    c.stage_four_after  = base * 3;
                    c.stage_five_after  = base * 4;
                    c.grace_period      = $urandom_range(300, 0);
                end
                2: begin
                    c.stage_two_after   = $urandom_range(1000, 0);
                    c.stage_three_after = $urandom_range(1000, 0);
                    c.stage_four_after  = $urandom_range(1000, 0);
                    c.stage_five_after  = $urandom_range(1000, 0);
                    c.grace_period      = $urandom_range(500, 0);
                end
                3: c = '0;
                4: c = '1;
                default: begin
                    c.stage_two_after   = $urandom();
                    c.stage_three_after = $urandom();
                    c.stage_four_after  = $urandom();
                    c.stage_five_after  = $urandom();
                    c.grace_period      = $urandom();
                end
            endcase
            load_limits(c);
            while (sample_count < 26 + (k + 1) * PHASE_SAMPLES) run_episode();
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("covered %0d samples under %0d limit settings, %0d stage changes seen",
                 reports_checked, setting_count + 1, stage_moves);
        if (mismatches == 0 && reports_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
